/* rtl/core/fcbd_pkg.sv */
package fcbd_pkg;

  typedef enum logic [1:0] {
    KIND_NEW  = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_BYTE    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam int unsigned BIGRAM_BASE = 128;
  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned TABLE_IDX_W = 7;

endpackage

/* rtl/core/front_coded_bigram_path_decoder_unit.sv */
// Throughput: one input transaction per cycle while the result queue holds at most two
// results; bigram bytes give two results, and the output side drains one result per
// cycle through a 4-entry result queue while out_ready is high.
// The bigram table is a 128 x 16 memory read with a registered port at input accept.
// Reset (rst, synchronous, active high) clears the decoder state and the queue;
// bigram table contents are undefined until loaded.
module front_coded_bigram_path_decoder_unit #(
  parameter int PATH_LENGTH_MAX = 1024,
  parameter int DELTA_BIAS      = 14,
  parameter int SWITCH_CODE     = 30,
  parameter int ESCAPE_CODE     = 31,
  parameter int WORD_BYTES      = 4,
  localparam int POS_W          = $clog2(PATH_LENGTH_MAX + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [7:0]         data_byte,
  input  logic [6:0]         table_index,
  input  logic [7:0]         table_first,
  input  logic [7:0]         table_second,
  input  logic [POS_W-1:0]   start_count,
  input  logic               skip_first,
  output logic               out_valid,
  input  logic               out_ready,
  output fcbd_pkg::kind_t    kind,
  output logic [POS_W-1:0]   position,
  output logic [7:0]         value,
  output logic               last
);
  import fcbd_pkg::*;

  localparam int WORD_W     = 8 * WORD_BYTES;
  localparam int SUM_W      = WORD_W + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  localparam logic [POS_W-1:0]        PATH_MAX_P = POS_W'(PATH_LENGTH_MAX);
  localparam logic signed [SUM_W-1:0] BIAS_S     = SUM_W'(DELTA_BIAS);
  localparam logic signed [SUM_W-1:0] MAX_S      = SUM_W'(PATH_LENGTH_MAX);
  localparam logic [7:0]              SWITCH_B   = 8'(SWITCH_CODE);
  localparam logic [7:0]              ESCAPE_B   = 8'(ESCAPE_CODE);

  // bigram table
  logic [15:0] bigram_mem [TABLE_DEPTH];
  logic [15:0] bigram_rd;

  // input register
  logic             a_valid;
  logic [1:0]       a_op;
  logic [7:0]       a_byte;
  logic [POS_W-1:0] a_start;
  logic             a_skip;
  logic             a_take;
  logic             in_accept;

  // decoder state
  logic [POS_W-1:0]  prefix_length, prefix_next;
  logic [POS_W-1:0]  write_position, write_position_next;
  logic              literal_pending, literal_pending_next;
  logic [2:0]        word_bytes_left, word_bytes_left_next;
  logic [WORD_W-1:0] word_acc, word_acc_next;
  logic              skip_pending, skip_pending_next;

  // results of the current transaction
  logic [1:0]        n_res;
  kind_t             r0_kind, r1_kind, d_kind;
  logic [POS_W-1:0]  r0_pos, r1_pos;
  logic [7:0]        r0_val, r1_val;
  logic [7:0]        ch0, ch1;
  logic              do_delta, do_char, two_chars;
  logic [WORD_W-1:0] acc_shift;
  logic signed [SUM_W-1:0] delta, sum;
  logic [POS_W-1:0]  wp_mid;

  // result queue
  kind_t            q_kind [FIFO_DEPTH];
  logic [POS_W-1:0] q_pos  [FIFO_DEPTH];
  logic [7:0]       q_val  [FIFO_DEPTH];
  logic             q_last [FIFO_DEPTH];
  logic [PTR_W-1:0] q_head, q_tail;
  logic [CNT_W-1:0] q_count;
  logic             q_pop;
  logic [1:0]       n_push;

  assign in_accept = in_valid && in_ready;
  assign a_take    = a_valid && (q_count <= CNT_W'(FIFO_DEPTH - 2));
  assign in_ready  = !a_valid || a_take;

  always_ff @(posedge clk) begin
    if (in_accept && operation == OP_LOAD) begin
      bigram_mem[table_index] <= {table_first, table_second};
    end
    if (in_accept) begin
      bigram_rd <= bigram_mem[data_byte[TABLE_IDX_W-1:0]];
      a_op      <= operation;
      a_byte    <= data_byte;
      a_start   <= start_count;
      a_skip    <= skip_first;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
  end

  always_comb begin
    prefix_next          = prefix_length;
    write_position_next  = write_position;
    literal_pending_next = literal_pending;
    word_bytes_left_next = word_bytes_left;
    word_acc_next        = word_acc;
    skip_pending_next    = skip_pending;
    n_res     = 2'd0;
    r0_kind   = KIND_NEW;
    r0_pos    = '0;
    r0_val    = 8'd0;
    r1_kind   = KIND_NEW;
    r1_pos    = '0;
    r1_val    = 8'd0;
    d_kind    = KIND_NEW;
    ch0       = a_byte;
    ch1       = 8'd0;
    do_delta  = 1'b0;
    do_char   = 1'b0;
    two_chars = 1'b0;
    wp_mid    = write_position;
    acc_shift = {word_acc[WORD_W-9:0], a_byte};
    delta     = $signed({{(SUM_W-8){1'b0}}, a_byte}) - BIAS_S;

    case (a_op)
      OP_BYTE: begin
        if (word_bytes_left != 3'd0) begin
          word_acc_next        = acc_shift;
          word_bytes_left_next = word_bytes_left - 3'd1;
          if (word_bytes_left == 3'd1) begin
            word_acc_next = '0;
            delta    = $signed({{2{acc_shift[WORD_W-1]}}, acc_shift}) - BIAS_S;
            do_delta = 1'b1;
          end
        end else if (literal_pending) begin
          literal_pending_next = 1'b0;
          do_char              = 1'b1;
        end else if (a_byte == SWITCH_B) begin
          word_bytes_left_next = 3'(WORD_BYTES);
          word_acc_next        = '0;
        end else if (a_byte < ESCAPE_B) begin
          do_delta = 1'b1;
        end else if (a_byte == ESCAPE_B) begin
          literal_pending_next = 1'b1;
        end else if (a_byte >= 8'(BIGRAM_BASE)) begin
          do_char   = 1'b1;
          two_chars = 1'b1;
          ch0       = bigram_rd[15:8];
          ch1       = bigram_rd[7:0];
        end else begin
          do_char = 1'b1;
        end
      end
      OP_RESTART: begin
        prefix_next          = (a_start > PATH_MAX_P) ? PATH_MAX_P : a_start;
        write_position_next  = (a_start > PATH_MAX_P) ? PATH_MAX_P : a_start;
        skip_pending_next    = a_skip;
        literal_pending_next = 1'b0;
        word_bytes_left_next = 3'd0;
        word_acc_next        = '0;
      end
      default: ;
    endcase

    sum = $signed({{(SUM_W-POS_W){1'b0}}, prefix_length}) + delta;

    if (do_delta) begin
      if (!skip_pending) begin
        if (sum < 0) begin
          prefix_next = '0;
          d_kind      = KIND_ERR;
        end else if (sum > MAX_S) begin
          prefix_next = PATH_MAX_P;
          d_kind      = KIND_ERR;
        end else begin
          prefix_next = sum[POS_W-1:0];
        end
      end
      skip_pending_next   = 1'b0;
      write_position_next = prefix_next;
      r0_kind = d_kind;
      r0_pos  = prefix_next;
      n_res   = 2'd1;
    end

    if (do_char) begin
      if (write_position < PATH_MAX_P) begin
        r0_kind = KIND_CHAR;
        r0_pos  = write_position;
        r0_val  = ch0;
        wp_mid  = write_position + POS_W'(1);
      end else begin
        r0_kind = KIND_ERR;
        r0_pos  = PATH_MAX_P;
        wp_mid  = PATH_MAX_P;
      end
      write_position_next = wp_mid;
      n_res = 2'd1;
      if (two_chars) begin
        if (wp_mid < PATH_MAX_P) begin
          r1_kind = KIND_CHAR;
          r1_pos  = wp_mid;
          r1_val  = ch1;
          write_position_next = wp_mid + POS_W'(1);
        end else begin
          r1_kind = KIND_ERR;
          r1_pos  = PATH_MAX_P;
          write_position_next = PATH_MAX_P;
        end
        n_res = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_length   <= '0;
      write_position  <= '0;
      literal_pending <= 1'b0;
      word_bytes_left <= 3'd0;
      word_acc        <= '0;
      skip_pending    <= 1'b0;
    end else if (a_take) begin
      prefix_length   <= prefix_next;
      write_position  <= write_position_next;
      literal_pending <= literal_pending_next;
      word_bytes_left <= word_bytes_left_next;
      word_acc        <= word_acc_next;
      skip_pending    <= skip_pending_next;
    end
  end

  assign n_push = a_take ? n_res : 2'd0;
  assign q_pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_kind[q_tail] <= r0_kind;
      q_pos[q_tail]  <= r0_pos;
      q_val[q_tail]  <= r0_val;
      q_last[q_tail] <= (n_push == 2'd1);
    end
    if (n_push == 2'd2) begin
      q_kind[q_tail + PTR_W'(1)] <= r1_kind;
      q_pos[q_tail + PTR_W'(1)]  <= r1_pos;
      q_val[q_tail + PTR_W'(1)]  <= r1_val;
      q_last[q_tail + PTR_W'(1)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      q_tail  <= q_tail + PTR_W'(n_push);
      q_head  <= q_head + PTR_W'(q_pop);
      q_count <= q_count + CNT_W'(n_push) - CNT_W'(q_pop);
    end
  end

  assign out_valid = (q_count != '0);
  assign kind      = q_kind[q_head];
  assign position  = q_pos[q_head];
  assign value     = q_val[q_head];
  assign last      = q_last[q_head];

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    write_position <= PATH_MAX_P && prefix_length <= PATH_MAX_P)
    else $error("path position out of range");

  a_mode_excl: assert property (@(posedge clk) disable iff (rst)
    !(literal_pending && word_bytes_left != 3'd0))
    else $error("literal pending inside switch word");

  a_new_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_CHAR) |-> value == 8'd0)
    else $error("nonzero value on non-character result");

endmodule

/* verif/front_coded_bigram_path_decoder_unit_tb.sv */
`timescale 1ns / 1ps

module front_coded_bigram_path_decoder_unit_tb;
  import fcbd_pkg::*;

  localparam int PATH_MAX    = 1024;
  localparam int DELTA_BIAS  = 14;
  localparam int SWITCH_CODE = 30;
  localparam int ESCAPE_CODE = 31;
  localparam int WORD_BYTES  = 4;
  localparam int POS_W       = $clog2(PATH_MAX + 1);
  localparam int ITEM_TARGET = 2000;

  typedef struct {
    kind_t            kind;
    logic [POS_W-1:0] position;
    logic [7:0]       value;
    logic             last;
  } decoded_t;

  class path_scoreboard;
    bit [15:0] bigram [TABLE_DEPTH];
    int        prefix_len;
    int        wr_pos;
    bit        lit_pend;
    int        word_left;
    bit [31:0] word_acc;
    bit        skip_pend;
    decoded_t  batch[$];
    decoded_t  expected_q[$];
    int        errors;

    function void add(kind_t k, int pos, bit [7:0] ch);
      decoded_t r;
      r.kind = k;
      r.position = pos[POS_W-1:0];
      r.value = ch;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    function void add_delta(longint delta);
      kind_t  k;
      longint nxt;
      k = KIND_NEW;
      if (!skip_pend) begin
        nxt = prefix_len + delta;
        if (nxt < 0) begin
          nxt = 0;
          k = KIND_ERR;
        end else if (nxt > PATH_MAX) begin
          nxt = PATH_MAX;
          k = KIND_ERR;
        end
        prefix_len = int'(nxt);
      end
      skip_pend = 1'b0;
      wr_pos = prefix_len;
      add(k, prefix_len, 8'd0);
    endfunction

    function void add_char(bit [7:0] ch);
      if (wr_pos < PATH_MAX) begin
        add(KIND_CHAR, wr_pos, ch);
        wr_pos++;
      end else begin
        wr_pos = PATH_MAX;
        add(KIND_ERR, PATH_MAX, 8'd0);
      end
    endfunction

    function void accept_transaction(logic [1:0] op, bit [7:0] b, bit [6:0] idx,
                                     bit [7:0] first, bit [7:0] second,
                                     bit [POS_W-1:0] sc, bit skip);
      longint span;
      longint raw;
      longint w;
      bit [15:0] e;
      batch.delete();
      span = longint'(1) << (8 * WORD_BYTES);
      case (op_t'(op))
        OP_LOAD: bigram[idx] = {first, second};
        OP_RESTART: begin
          prefix_len = (sc > PATH_MAX) ? PATH_MAX : int'(sc);
          wr_pos = prefix_len;
          skip_pend = skip;
          lit_pend = 1'b0;
          word_left = 0;
          word_acc = '0;
        end
        OP_BYTE: begin
          if (word_left > 0) begin
            word_acc = (word_acc << 8) | 32'(b);
            word_left--;
            if (word_left == 0) begin
              raw = longint'(word_acc) & (span - 1);
              w = raw;
              if ((raw & (span >> 1)) != 0) w = raw - span;
              word_acc = '0;
              add_delta(w - DELTA_BIAS);
            end
          end else if (lit_pend) begin
            lit_pend = 1'b0;
            add_char(b);
          end else if (b == SWITCH_CODE) begin
            word_left = WORD_BYTES;
            word_acc = '0;
          end else if (b < ESCAPE_CODE) begin
            add_delta(longint'(b) - DELTA_BIAS);
          end else if (b == ESCAPE_CODE) begin
            lit_pend = 1'b1;
          end else if (b >= BIGRAM_BASE) begin
            e = bigram[b - BIGRAM_BASE];
            add_char(e[15:8]);
            add_char(e[7:0]);
          end else begin
            add_char(b);
          end
        end
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_q.push_back(batch[i]);
    endfunction

    function void check_result(kind_t k, logic [POS_W-1:0] pos, logic [7:0] val,
                               logic lst);
      decoded_t x;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d position %0d value %0d last %0b",
                   k, pos, val, lst);
        return;
      end
      x = expected_q.pop_front();
      if (x.kind !== k || x.position !== pos || x.value !== val || x.last !== lst) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected kind %0d position %0d value %0d last %0b, %s",
                   x.kind, x.position, x.value, x.last,
                   $sformatf("got kind %0d position %0d value %0d last %0b",
                             k, pos, val, lst));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       operation = OP_NONE;
  logic [7:0]       data_byte = '0;
  logic [6:0]       table_index = '0;
  logic [7:0]       table_first = '0;
  logic [7:0]       table_second = '0;
  logic [POS_W-1:0] start_count = '0;
  logic             skip_first = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  kind_t            kind;
  logic [POS_W-1:0] position;
  logic [7:0]       value;
  logic             last;

  path_scoreboard sb;
  bit             calm;
  bit             table_loaded [TABLE_DEPTH];
  int             items_sent;

  front_coded_bigram_path_decoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .data_byte    (data_byte),
    .table_index  (table_index),
    .table_first  (table_first),
    .table_second (table_second),
    .start_count  (start_count),
    .skip_first   (skip_first),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .position     (position),
    .value        (value),
    .last         (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.accept_transaction(operation, data_byte, table_index, table_first,
                              table_second, start_count, skip_first);
      if (out_valid && out_ready)
        sb.check_result(kind, position, value, last);
    end
  end

  task automatic send(op_t op, bit [7:0] b, bit [6:0] idx, bit [7:0] first,
                      bit [7:0] second, bit [POS_W-1:0] sc, bit skip);
    if (!calm) begin
      while ($urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    operation    <= op;
    data_byte    <= b;
    table_index  <= idx;
    table_first  <= first;
    table_second <= second;
    start_count  <= sc;
    skip_first   <= skip;
    do @(posedge clk); while (!in_ready);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic send_load(bit [6:0] idx, bit [7:0] first, bit [7:0] second);
    send(OP_LOAD, 8'($urandom), idx, first, second, POS_W'($urandom), 1'($urandom));
    table_loaded[idx] = 1'b1;
  endtask

  task automatic send_restart(bit [POS_W-1:0] sc, bit skip);
    send(OP_RESTART, 8'($urandom), 7'($urandom), 8'($urandom), 8'($urandom), sc, skip);
  endtask

  // entries are loaded lazily so that a bigram lookup never hits an unwritten slot
  task automatic send_byte(bit [7:0] b);
    if (b >= BIGRAM_BASE && !table_loaded[b - BIGRAM_BASE])
      send_load(7'(b - BIGRAM_BASE), 8'($urandom), 8'($urandom));
    send(OP_BYTE, b, 7'($urandom), 8'($urandom), 8'($urandom), POS_W'($urandom),
         1'($urandom));
  endtask

  task automatic send_switch(bit [31:0] w);
    send_byte(8'(SWITCH_CODE));
    for (int i = WORD_BYTES - 1; i >= 0; i--) send_byte(w[i*8 +: 8]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_path();
    int n;
    int sel;
    if ($urandom_range(0, 99) < 80) begin
      send_byte(8'($urandom_range(0, SWITCH_CODE - 1)));
    end else if ($urandom_range(0, 1) == 1) begin
      send_switch(32'(DELTA_BIAS + int'($urandom_range(0, 80)) - 40));
    end else begin
      send_switch($urandom);
    end
    n = $urandom_range(1, 12);
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        send_byte(8'($urandom_range(ESCAPE_CODE + 1, BIGRAM_BASE - 1)));
      end else if (sel < 80) begin
        send_byte(8'($urandom_range(BIGRAM_BASE, 255)));
      end else begin
        send_byte(8'(ESCAPE_CODE));
        send_byte(8'($urandom));
      end
    end
  endtask

  task automatic send_random_restart();
    int sel;
    bit [POS_W-1:0] sc;
    sel = $urandom_range(0, 2);
    if (sel == 0) sc = POS_W'($urandom);
    else if (sel == 1) sc = POS_W'($urandom_range(PATH_MAX - 24, PATH_MAX));
    else sc = POS_W'($urandom_range(0, 20));
    send_restart(sc, 1'($urandom));
  endtask

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int sel;
    int guard;
    bit paused;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_load(7'd0, 8'h00, 8'hFF);
    send_load(7'd127, 8'hFF, 8'h00);
    send_restart('0, 1'b0);
    send_byte(8'd0);
    send_byte(8'd29);
    send_byte(8'd32);
    send_byte(8'd127);
    send_byte(8'(ESCAPE_CODE));
    send_byte(8'd0);
    send_byte(8'(ESCAPE_CODE));
    send_byte(8'd255);
    send_byte(8'd128);
    send(OP_NONE, 8'hFF, 7'h7F, 8'hFF, 8'hFF, '1, 1'b1);
    send_switch(32'h0000_040E);
    send_byte(8'd65);
    send_restart('1, 1'b1);
    send_byte(8'd14);
    send_byte(8'(ESCAPE_CODE));
    send_restart(POS_W'(PATH_MAX - 2), 1'b0);
    send_byte(8'd14);
    send_byte(8'd128);
    send_byte(8'd255);
    send_restart(POS_W'(5), 1'b1);
    send_switch(32'hFFFF_FFFF);
    send_switch(32'hFFFF_FFFF);
    drain();

    paused = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= 1400 && items_sent < 1700);
      if (!paused && items_sent >= 1000) begin
        paused = 1'b1;
        drain();
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        send_path();
      end else if (sel < 80) begin
        send_random_restart();
      end else if (sel < 88) begin
        send_load(7'($urandom), 8'($urandom), 8'($urandom));
      end else if (sel < 98) begin
        send_byte(8'($urandom));
      end else if (sel == 98) begin
        send(OP_NONE, 8'($urandom), 7'($urandom), 8'($urandom), 8'($urandom),
             POS_W'($urandom), 1'($urandom));
      end else begin
        // switch word cut short by a restart
        send_byte(8'(SWITCH_CODE));
        send_byte(8'($urandom));
        send_random_restart();
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/fcbd_pkg.sv
rtl/core/front_coded_bigram_path_decoder_unit.sv
verif/front_coded_bigram_path_decoder_unit_tb.sv
